[rtl/ellipse_tangent_points_assert.svh]
`ifndef ELLIPSE_TANGENT_POINTS_ASSERT_SVH
`define ELLIPSE_TANGENT_POINTS_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define ETP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("etp assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define ETP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("etp assertion failed");

`endif

[rtl/etp_pkg.sv]
package etp_pkg;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_IN_X   = 2'd1;
  localparam logic [1:0] ST_IN_Y   = 2'd2;
  localparam logic [1:0] ST_ORIGIN = 2'd3;

  localparam logic [7:0] REG_X_RADIUS = 8'd0;
  localparam logic [7:0] REG_Y_RADIUS = 8'd1;

  localparam logic [19:0] THRESH_INV = 20'd1000000;

  typedef struct packed {
    logic        nx;
    logic        ny;
    logic [31:0] ax;
    logic [31:0] ay;
    logic        org;
    logic [1:0]  icode;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic       org;
    logic       interior;
    logic       dzero;
    logic [1:0] icode;
  } meta_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] first_x;
    logic [31:0] first_y;
    logic [31:0] second_x;
    logic [31:0] second_y;
  } result_t;

endpackage

[rtl/ellipse_tangent_points.sv]
// throughput: one request per cycle unless m_axis_tready stalls the output,
// set by the fully pipelined back end
// (64-stage square root, four 33-stage dividers, multipliers cut into 32x32 steps)
// a four-entry queue parts the classifying front end from the arithmetic back end
// reset: synchronous, clears all valid state and loads both radii with 1.0
`include "ellipse_tangent_points_assert.svh"

module ellipse_tangent_points #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // point_x, point_y
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // first_x, first_y, second_x, second_y
  output logic [1:0]   m_axis_tuser,   // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [31:0]       x_radius;
  logic [31:0]       y_radius;
  logic [63:0]       rx2;
  logic [63:0]       ry2;
  logic              push;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  logic              en;
  etp_pkg::item_t    fr_item;
  etp_pkg::item_t    head;
  logic              bk_valid;
  etp_pkg::result_t  bk_res;
  logic              res_valid;
  etp_pkg::result_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_radius <= 32'(1) << FRAC_BITS;
      y_radius <= 32'(1) << FRAC_BITS;
    end else if (cfg_valid) begin
      if (cfg_index == etp_pkg::REG_X_RADIUS) x_radius <= cfg_data;
      if (cfg_index == etp_pkg::REG_Y_RADIUS) y_radius <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    rx2 <= 64'(x_radius) * 64'(x_radius);
    ry2 <= 64'(y_radius) * 64'(y_radius);
  end

  etp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_x(s_axis_tdata[31:0]),
    .in_y(s_axis_tdata[63:32]),
    .rx2, .ry2,
    .full(q_full),
    .push,
    .item(fr_item)
  );

  etp_queue #(.W($bits(etp_pkg::item_t)), .DEPTH(4)) u_queue (
    .clk, .rst,
    .push,
    .din(fr_item),
    .pop,
    .dout(head),
    .full(q_full),
    .empty(q_empty)
  );

  assign en  = !res_valid || m_axis_tready;
  assign pop = en && !q_empty;

  etp_back u_back (
    .clk, .rst, .en,
    .in_valid(pop),
    .head,
    .rx2, .ry2,
    .out_valid(bk_valid),
    .res(bk_res)
  );

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (en) res_valid <= bk_valid;
  end

  always_ff @(posedge clk) begin
    if (en) res <= bk_res;
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {res.second_y, res.second_x, res.first_y, res.first_x};
  assign m_axis_tuser  = res.status;

  `ETP_ASSERT_IMP(a_bad_status_zero, m_axis_tvalid && (m_axis_tuser != etp_pkg::ST_OK), m_axis_tdata == '0)
  `ETP_ASSERT_NXT(a_stall_holds, !en, $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `ETP_ASSERT_IMP(a_queue_flags, q_full, !q_empty)

endmodule

[rtl/etp_front.sv]
module etp_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_x,
  input  logic [31:0]       in_y,
  input  logic [63:0]       rx2,
  input  logic [63:0]       ry2,
  input  logic              full,
  output logic              push,
  output etp_pkg::item_t    item
);

  logic        en;
  logic        sa_valid;
  logic [31:0] sa_x;
  logic [31:0] sa_y;
  logic        sb_valid;
  logic        sb_nx;
  logic        sb_ny;
  logic [31:0] sb_ax;
  logic [31:0] sb_ay;
  logic [51:0] sb_mx;
  logic [51:0] sb_my;
  logic [31:0] ax_c;
  logic [31:0] ay_c;
  logic        xbr;
  logic        ybr;

  assign en       = !sb_valid || !full;
  assign in_ready = en;

  assign ax_c = sa_x[31] ? (32'd0 - sa_x) : sa_x;
  assign ay_c = sa_y[31] ? (32'd0 - sa_y) : sa_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
      sb_valid <= 1'b0;
    end else if (en) begin
      sa_valid <= in_valid;
      sb_valid <= sa_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_x  <= in_x;
      sa_y  <= in_y;
      sb_nx <= sa_x[31];
      sb_ny <= sa_y[31];
      sb_ax <= ax_c;
      sb_ay <= ay_c;
      sb_mx <= 52'(ax_c) * 52'(etp_pkg::THRESH_INV);
      sb_my <= 52'(ay_c) * 52'(etp_pkg::THRESH_INV);
    end
  end

  assign xbr  = 64'(sb_mx) > (rx2 >> FRAC_BITS);
  assign ybr  = 64'(sb_my) > (ry2 >> FRAC_BITS);
  assign push = sb_valid && !full;

  assign item.nx    = sb_nx;
  assign item.ny    = sb_ny;
  assign item.ax    = sb_ax;
  assign item.ay    = sb_ay;
  assign item.org   = !xbr && !ybr;
  assign item.icode = xbr ? etp_pkg::ST_IN_X : etp_pkg::ST_IN_Y;

endmodule

[rtl/etp_queue.sv]
module etp_queue #(
  parameter int W     = 68,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr;
  logic [AW-1:0] rd;
  logic [CW-1:0] cnt;
  logic [AW-1:0] wr_next;
  logic [AW-1:0] rd_next;

  assign full    = cnt == CW'(DEPTH);
  assign empty   = cnt == '0;
  assign dout    = mem[rd];
  assign wr_next = (wr == AW'(DEPTH - 1)) ? '0 : wr + 1'b1;
  assign rd_next = (rd == AW'(DEPTH - 1)) ? '0 : rd + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= '0;
      rd  <= '0;
      cnt <= '0;
    end else begin
      if (push) wr <= wr_next;
      if (pop) rd <= rd_next;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr] <= din;
  end

endmodule

[rtl/etp_mul.sv]
module etp_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int NA = (AW + 31) / 32;
  localparam int NB = (BW + 31) / 32;
  localparam int NS = NA * NB;
  localparam int AP = NA * 32;
  localparam int BP = NB * 32;
  localparam int QW = AP + BP;

  logic [AP-1:0] a_s   [NS];
  logic [BP-1:0] b_s   [NS];
  logic [QW-1:0] acc_s [NS];

  genvar i;
  generate
    for (i = 0; i < NS; i++) begin : g_st
      localparam int IA = i / NB;
      localparam int IB = i % NB;
      logic [AP-1:0] a_in;
      logic [BP-1:0] b_in;
      logic [QW-1:0] acc_in;
      logic [63:0]   pp;
      if (i == 0) begin : g_first
        assign a_in   = AP'(a);
        assign b_in   = BP'(b);
        assign acc_in = '0;
      end else begin : g_next
        assign a_in   = a_s[i-1];
        assign b_in   = b_s[i-1];
        assign acc_in = acc_s[i-1];
      end
      assign pp = 64'(a_in[32*IA +: 32]) * 64'(b_in[32*IB +: 32]);
      always_ff @(posedge clk) begin
        if (en) begin
          a_s[i]   <= a_in;
          b_s[i]   <= b_in;
          acc_s[i] <= acc_in + (QW'(pp) << (32 * (IA + IB)));
        end
      end
    end
  endgenerate

  assign p = acc_s[NS-1][AW+BW-1:0];

endmodule

[rtl/etp_sqrt.sv]
module etp_sqrt (
  input  logic         clk,
  input  logic         en,
  input  logic [127:0] n,
  output logic [63:0]  root
);

  logic [127:0] rem_s [64];
  logic [63:0]  rt_s  [64];

  genvar j;
  generate
    for (j = 0; j < 64; j++) begin : g_st
      localparam int B = 63 - j;
      logic [127:0] rem_in;
      logic [63:0]  rt_in;
      logic [128:0] t;
      if (j == 0) begin : g_first
        assign rem_in = n;
        assign rt_in  = '0;
      end else begin : g_next
        assign rem_in = rem_s[j-1];
        assign rt_in  = rt_s[j-1];
      end
      // (r + 2^b)^2 - r^2
      assign t = (129'(rt_in) << (B + 1)) | (129'(1) << (2 * B));
      always_ff @(posedge clk) begin
        if (en) begin
          if (129'(rem_in) >= t) begin
            rem_s[j] <= rem_in - t[127:0];
            rt_s[j]  <= rt_in | (64'(1) << B);
          end else begin
            rem_s[j] <= rem_in;
            rt_s[j]  <= rt_in;
          end
        end
      end
    end
  endgenerate

  assign root = rt_s[63];

endmodule

[rtl/etp_div.sv]
module etp_div (
  input  logic         clk,
  input  logic         en,
  input  logic [161:0] n,
  input  logic [128:0] dv,
  output logic [31:0]  q,
  output logic         sat
);

  logic [161:0] r0;
  logic [128:0] dv0;
  logic         sat0;
  logic [161:0] rem_s [32];
  logic [128:0] dv_s  [32];
  logic [31:0]  q_s   [32];
  logic         sat_s [32];

  always_ff @(posedge clk) begin
    if (en) begin
      r0   <= n;
      dv0  <= dv;
      sat0 <= n >= 162'({dv, 32'd0});
    end
  end

  genvar j;
  generate
    for (j = 0; j < 32; j++) begin : g_st
      localparam int K = 31 - j;
      logic [161:0] rem_in;
      logic [128:0] dv_in;
      logic [31:0]  q_in;
      logic         sat_in;
      logic [161:0] sh;
      if (j == 0) begin : g_first
        assign rem_in = r0;
        assign dv_in  = dv0;
        assign q_in   = '0;
        assign sat_in = sat0;
      end else begin : g_next
        assign rem_in = rem_s[j-1];
        assign dv_in  = dv_s[j-1];
        assign q_in   = q_s[j-1];
        assign sat_in = sat_s[j-1];
      end
      assign sh = 162'(dv_in) << K;
      always_ff @(posedge clk) begin
        if (en) begin
          dv_s[j]  <= dv_in;
          sat_s[j] <= sat_in;
          if (rem_in >= sh) begin
            rem_s[j] <= rem_in - sh;
            q_s[j]   <= q_in | (32'(1) << K);
          end else begin
            rem_s[j] <= rem_in;
            q_s[j]   <= q_in;
          end
        end
      end
    end
  endgenerate

  assign q   = q_s[31];
  assign sat = sat_s[31];

endmodule

[rtl/etp_dly.sv]
module etp_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) sr[i] <= '0;
    end else if (en) begin
      sr[0] <= d;
      for (int i = 1; i < N; i++) sr[i] <= sr[i-1];
    end
  end

  assign q = sr[N-1];

endmodule

[rtl/etp_back.sv]
module etp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  etp_pkg::item_t     head,
  input  logic [63:0]        rx2,
  input  logic [63:0]        ry2,
  output logic               out_valid,
  output etp_pkg::result_t   res
);

  logic [63:0]   aa;
  logic [63:0]   bb;
  logic [127:0]  k4;
  logic [127:0]  kd;
  logic [127:0]  d1;
  logic [127:0]  d2;
  logic [127:0]  d6;
  logic [127:0]  d7;
  logic [127:0]  dk7;
  logic          in7;
  logic          dz7;
  logic [127:0]  d80;
  logic [3:0]    m7;
  etp_pkg::meta_t mt7;
  etp_pkg::meta_t mt113;
  logic [63:0]   e71;
  logic [65:0]   side71;
  logic [1:0]    sg73;
  logic [95:0]   p73;
  logic [95:0]   r73;
  logic [95:0]   q73;
  logic [95:0]   s73;
  logic [97:0]   sp;
  logic [97:0]   sq;
  logic [97:0]   sr;
  logic [97:0]   ss;
  logic [97:0]   v [4];
  logic [95:0]   mag74 [4];
  logic [3:0]    neg74;
  logic [3:0]    neg113;
  logic [159:0]  num80 [4];
  logic [31:0]   q113 [4];
  logic [3:0]    sat113;
  logic [31:0]   coord [4];
  logic [1:0]    status;

  etp_mul #(.AW(32), .BW(32)) u_aa (.clk, .en, .a(head.ax), .b(head.ax), .p(aa));
  etp_mul #(.AW(32), .BW(32)) u_bb (.clk, .en, .a(head.ay), .b(head.ay), .p(bb));
  etp_mul #(.AW(64), .BW(64)) u_k (.clk, .en, .a(rx2), .b(ry2), .p(k4));
  etp_mul #(.AW(64), .BW(64)) u_d1 (.clk, .en, .a(aa), .b(ry2), .p(d1));
  etp_mul #(.AW(64), .BW(64)) u_d2 (.clk, .en, .a(bb), .b(rx2), .p(d2));

  etp_dly #(.W(128), .N(2)) u_kd (.clk, .rst, .en, .d(k4), .q(kd));

  always_ff @(posedge clk) begin
    if (en) begin
      d6  <= d1 + d2;
      d7  <= d6;
      dk7 <= d6 - kd;
      in7 <= d6 < kd;
      dz7 <= d6 == '0;
    end
  end

  etp_dly #(.W(4), .N(7)) u_m0 (
    .clk, .rst, .en, .d({in_valid, head.org, head.icode}), .q(m7)
  );

  assign mt7.valid    = m7[3];
  assign mt7.org      = m7[2];
  assign mt7.interior = in7;
  assign mt7.dzero    = dz7;
  assign mt7.icode    = m7[1:0];

  etp_dly #(.W($bits(etp_pkg::meta_t)), .N(106)) u_m1 (
    .clk, .rst, .en, .d(mt7), .q(mt113)
  );

  etp_sqrt u_sq (.clk, .en, .n(dk7), .root(e71));

  etp_dly #(.W(66), .N(71)) u_s0 (
    .clk, .rst, .en, .d({head.nx, head.ny, head.ax, head.ay}), .q(side71)
  );
  etp_dly #(.W(2), .N(2)) u_s1 (.clk, .rst, .en, .d(side71[65:64]), .q(sg73));

  etp_mul #(.AW(32), .BW(64)) u_p (.clk, .en, .a(side71[63:32]), .b(ry2), .p(p73));
  etp_mul #(.AW(32), .BW(64)) u_r (.clk, .en, .a(side71[31:0]), .b(rx2), .p(r73));
  etp_mul #(.AW(32), .BW(64)) u_q (.clk, .en, .a(side71[31:0]), .b(e71), .p(q73));
  etp_mul #(.AW(32), .BW(64)) u_s (.clk, .en, .a(side71[63:32]), .b(e71), .p(s73));

  assign sp = sg73[1] ? (98'd0 - 98'(p73)) : 98'(p73);
  assign ss = sg73[1] ? (98'd0 - 98'(s73)) : 98'(s73);
  assign sq = sg73[0] ? (98'd0 - 98'(q73)) : 98'(q73);
  assign sr = sg73[0] ? (98'd0 - 98'(r73)) : 98'(r73);

  assign v[0] = sp - sq;
  assign v[1] = sr + ss;
  assign v[2] = sp + sq;
  assign v[3] = sr - ss;

  etp_dly #(.W(128), .N(73)) u_dd (.clk, .rst, .en, .d(d7), .q(d80));
  etp_dly #(.W(4), .N(39)) u_ng (.clk, .rst, .en, .d(neg74), .q(neg113));

  genvar i;
  generate
    for (i = 0; i < 4; i++) begin : g_c
      always_ff @(posedge clk) begin
        if (en) begin
          neg74[i] <= v[i][97];
          mag74[i] <= v[i][97] ? 96'(98'd0 - v[i]) : v[i][95:0];
        end
      end

      etp_mul #(.AW(64), .BW(96)) u_n (
        .clk, .en, .a((i % 2 == 0) ? rx2 : ry2), .b(mag74[i]), .p(num80[i])
      );

      etp_div u_dv (
        .clk, .en,
        .n({num80[i], 1'b0} + 162'(d80)),
        .dv({d80, 1'b0}),
        .q(q113[i]),
        .sat(sat113[i])
      );

      always_comb begin
        if (status != etp_pkg::ST_OK || mt113.dzero) begin
          coord[i] = '0;
        end else if (neg113[i]) begin
          coord[i] = (sat113[i] || q113[i] > 32'h8000_0000) ? 32'h8000_0000
                                                           : 32'd0 - q113[i];
        end else begin
          coord[i] = (sat113[i] || q113[i] > 32'h7fff_ffff) ? 32'h7fff_ffff : q113[i];
        end
      end
    end
  endgenerate

  always_comb begin
    if (mt113.org) status = etp_pkg::ST_ORIGIN;
    else if (mt113.interior) status = mt113.icode;
    else status = etp_pkg::ST_OK;
  end

  assign out_valid    = mt113.valid;
  assign res.status   = status;
  assign res.first_x  = coord[0];
  assign res.first_y  = coord[1];
  assign res.second_x = coord[2];
  assign res.second_y = coord[3];

endmodule
